// ===== sv/fnvmt_pkg.sv =====
// Shared types and constants for the FNV-1a hash tree builder.
// No dependencies; imported by every module of the block.
package fnvmt_pkg;

   localparam int HASH_W = 32;
   localparam int POS_W  = 6;
   localparam int LC_W   = 6;
   localparam int STEP_W = 3;

   localparam logic [HASH_W-1:0] FNV_SEED  = 32'h811C_9DC5;
   localparam logic [HASH_W-1:0] FNV_PRIME = 32'd16777619;
   localparam logic [7:0]        BYTE_MASK = 8'hFF;

   // eight bytes per parent: four of the left child, four of the right
   localparam logic [STEP_W-1:0] FIRST_BYTE = 3'd0;
   localparam logic [STEP_W-1:0] LAST_BYTE  = 3'd7;

   typedef struct packed {
      logic init;   // load left word, restart from the seed
      logic step;   // mix one byte
   } hash_ctl_type;

   typedef struct packed {
      logic last_step;  // final byte is being mixed this cycle
   } hash_sts_type;

endpackage

// ===== sv/fnvmt_node_ram.sv =====
// Tree word storage: one write port, one read port, registered read data.
// Depends on fnvmt_pkg.
module fnvmt_node_ram
   import fnvmt_pkg::*;
#(
   parameter int DEPTH  = 63,
   parameter int ADDR_W = 6
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [HASH_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [HASH_W-1:0] rd_data
);

   logic [HASH_W-1:0] node_ff [DEPTH];
   logic [HASH_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         node_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= node_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/fnvmt_hash_unit.sv =====
// Byte-serial FNV-1a mixer over a left/right word pair, one multiply a cycle while step is high.
// Depends on fnvmt_pkg.
module fnvmt_hash_unit
   import fnvmt_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  hash_ctl_type      ctl,
   input  logic [HASH_W-1:0] word_in,
   output logic [HASH_W-1:0] hash,
   output hash_sts_type      sts
);

   logic [STEP_W-1:0]   cnt_ff, cnt_in;
   logic [2*HASH_W-1:0] op_ff, op_in;
   logic [HASH_W-1:0]   h_ff, h_in;
   logic [HASH_W-1:0]   mix;

   assign mix = (h_ff ^ {24'h0, op_ff[7:0] & BYTE_MASK}) * FNV_PRIME;

   always_comb begin
      op_in  = op_ff;
      h_in   = h_ff;
      cnt_in = cnt_ff;
      if (ctl.init) begin
         op_in  = {32'h0, word_in};
         h_in   = FNV_SEED;
         cnt_in = FIRST_BYTE;
      end else if (ctl.step) begin
         // right word arrives from the RAM on the first byte step
         if (cnt_ff == FIRST_BYTE) begin
            op_in = {8'h0, word_in, op_ff[31:8]};
         end else begin
            op_in = {8'h0, op_ff[63:8]};
         end
         h_in   = mix;
         cnt_in = cnt_ff + 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= FIRST_BYTE;
      end else begin
         cnt_ff <= cnt_in;
      end
      op_ff <= op_in;
      h_ff  <= h_in;
   end

   assign hash          = h_ff;
   assign sts.last_step = ctl.step && (cnt_ff == LAST_BYTE);

endmodule

// ===== sv/fnv1a_merkle_tree_builder.sv =====
// Top level of the FNV-1a hash tree builder: leaf intake, tree sequencer, output.
// Depends on fnvmt_pkg, fnvmt_node_ram and fnvmt_hash_unit.
//
//   channel | direction | ports                                      | item
//   req     | in        | req_valid/ready, leaf_hash, last_leaf      | one leaf
//   rsp     | out       | rsp_valid/ready, node_hash, node_position, | one tree word
//           |           | leaf_count, last_node, overflow_error      |
//
// A leaf that is not last is stored while room is left. On the last leaf the
// tree is sized, then each internal node takes two RAM reads, eight byte steps
// on the single multiplier and one write-back, then each emitted word takes a
// RAM read and a hold until taken; an overflowed set gives one error word instead.
// No leaf is taken while a tree is being built or emitted. Reset clears only
// control state; the RAM needs no clearing, every word is written before read.
module fnv1a_merkle_tree_builder
   import fnvmt_pkg::*;
#(
   parameter int MAX_LEAVES = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [HASH_W-1:0] req_leaf_hash,
   input  logic              req_last_leaf,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [HASH_W-1:0] rsp_node_hash,
   output logic [POS_W-1:0]  rsp_node_position,
   output logic [LC_W-1:0]   rsp_leaf_count,
   output logic              rsp_last_node,
   output logic              rsp_overflow_error
);

   localparam int LEAF_CAP = 1 << $clog2(MAX_LEAVES);
   localparam int ADDR_W   = $clog2(2 * LEAF_CAP);
   localparam int DEPTH    = 2 * LEAF_CAP - 1;
   localparam logic [ADDR_W-1:0] LEAF_BASE = ADDR_W'(LEAF_CAP - 1);
   localparam logic [ADDR_W-1:0] MAX_CNT   = ADDR_W'(MAX_LEAVES);

   localparam logic [3:0] ST_IDLE = 4'd0;
   localparam logic [3:0] ST_PREP = 4'd1;
   localparam logic [3:0] ST_RDL  = 4'd2;
   localparam logic [3:0] ST_RDR  = 4'd3;
   localparam logic [3:0] ST_MIX  = 4'd4;
   localparam logic [3:0] ST_WR   = 4'd5;
   localparam logic [3:0] ST_ERD  = 4'd6;
   localparam logic [3:0] ST_EOUT = 4'd7;
   localparam logic [3:0] ST_ERR  = 4'd8;

   logic [3:0]        state_ff, state_in;
   logic [ADDR_W-1:0] loaded_ff, loaded_in;
   logic              ovf_ff, ovf_in;
   logic [ADDR_W-1:0] n_ff, n_in;
   logic [ADDR_W-1:0] lc_ff, lc_in;
   logic [ADDR_W-1:0] p_ff, p_in;
   logic [ADDR_W-1:0] pos_ff, pos_in;
   logic              pad_ff;

   logic              leaf_acc, leaf_store;
   logic [ADDR_W-1:0] lc_calc;
   logic [ADDR_W:0]   child_dbl;
   logic [ADDR_W-1:0] child, leaf_start, leaf_idx;
   logic [ADDR_W-1:0] last_pos;
   logic              rd_en, rd_pad;
   logic [ADDR_W-1:0] rd_addr;
   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic [HASH_W-1:0] wr_data, rd_data, word, hash;
   hash_ctl_type      hctl;
   hash_sts_type      hsts;

   assign req_ready  = (state_ff == ST_IDLE);
   assign leaf_acc   = req_valid && req_ready;
   assign leaf_store = (loaded_ff < MAX_CNT);

   // padded leaf count: smallest power of two not below n
   always_comb begin
      lc_calc = ADDR_W'(1);
      for (int k = 0; k < ADDR_W; k++) begin
         if (lc_calc < n_ff) begin
            lc_calc = lc_calc << 1;
         end
      end
   end

   // heap position to RAM address; leaves live at their place in the largest tree
   always_comb begin
      child_dbl = {p_ff, 1'b0};
      case (state_ff)
         ST_RDL:  child = ADDR_W'(child_dbl + (ADDR_W+1)'(1));
         ST_RDR:  child = ADDR_W'(child_dbl + (ADDR_W+1)'(2));
         default: child = pos_ff;
      endcase
      leaf_start = lc_ff - ADDR_W'(1);
      leaf_idx   = child - leaf_start;
      if (child < leaf_start) begin
         rd_addr = child;
         rd_pad  = 1'b0;
      end else begin
         rd_addr = LEAF_BASE + leaf_idx;
         rd_pad  = (leaf_idx >= n_ff);
      end
   end

   assign rd_en    = (state_ff == ST_RDL) || (state_ff == ST_RDR) || (state_ff == ST_ERD);
   assign word     = pad_ff ? FNV_SEED : rd_data;
   assign last_pos = ADDR_W'({lc_ff, 1'b0} - (ADDR_W+1)'(2));

   assign wr_en   = (leaf_acc && leaf_store) || (state_ff == ST_WR);
   assign wr_addr = (state_ff == ST_WR) ? p_ff : LEAF_BASE + loaded_ff;
   assign wr_data = (state_ff == ST_WR) ? hash : req_leaf_hash;

   assign hctl.init = (state_ff == ST_RDR);
   assign hctl.step = (state_ff == ST_MIX);

   always_comb begin
      state_in  = state_ff;
      loaded_in = loaded_ff;
      ovf_in    = ovf_ff;
      n_in      = n_ff;
      lc_in     = lc_ff;
      p_in      = p_ff;
      pos_in    = pos_ff;
      case (state_ff)
         ST_IDLE: begin
            if (leaf_acc) begin
               if (leaf_store) begin
                  loaded_in = loaded_ff + ADDR_W'(1);
               end else begin
                  ovf_in = 1'b1;
               end
               if (req_last_leaf) begin
                  loaded_in = '0;
                  ovf_in    = 1'b0;
                  n_in      = loaded_ff + ADDR_W'(1);
                  state_in  = (ovf_ff || !leaf_store) ? ST_ERR : ST_PREP;
               end
            end
         end
         ST_PREP: begin
            lc_in    = lc_calc;
            p_in     = lc_calc - ADDR_W'(2);
            pos_in   = '0;
            state_in = (lc_calc == ADDR_W'(1)) ? ST_ERD : ST_RDL;
         end
         ST_RDL:  state_in = ST_RDR;
         ST_RDR:  state_in = ST_MIX;
         ST_MIX: begin
            if (hsts.last_step) begin
               state_in = ST_WR;
            end
         end
         ST_WR: begin
            if (p_ff == '0) begin
               state_in = ST_ERD;
            end else begin
               p_in     = p_ff - ADDR_W'(1);
               state_in = ST_RDL;
            end
         end
         ST_ERD:  state_in = ST_EOUT;
         ST_EOUT: begin
            if (rsp_ready) begin
               if (pos_ff == last_pos) begin
                  state_in = ST_IDLE;
               end else begin
                  pos_in   = pos_ff + ADDR_W'(1);
                  state_in = ST_ERD;
               end
            end
         end
         ST_ERR: begin
            if (rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         loaded_ff <= '0;
         ovf_ff    <= 1'b0;
      end else begin
         state_ff  <= state_in;
         loaded_ff <= loaded_in;
         ovf_ff    <= ovf_in;
      end
      n_ff   <= n_in;
      lc_ff  <= lc_in;
      p_ff   <= p_in;
      pos_ff <= pos_in;
      if (rd_en) begin
         pad_ff <= rd_pad;
      end
   end

   fnvmt_node_ram #(
      .DEPTH  (DEPTH),
      .ADDR_W (ADDR_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   fnvmt_hash_unit u_hash (
      .clock   (clock),
      .reset   (reset),
      .ctl     (hctl),
      .word_in (word),
      .hash    (hash),
      .sts     (hsts)
   );

   always_comb begin
      rsp_valid          = (state_ff == ST_EOUT) || (state_ff == ST_ERR);
      rsp_overflow_error = (state_ff == ST_ERR);
      if (state_ff == ST_ERR) begin
         rsp_node_hash     = '0;
         rsp_node_position = '0;
         rsp_leaf_count    = '0;
         rsp_last_node     = 1'b1;
      end else begin
         rsp_node_hash     = word;
         rsp_node_position = POS_W'(pos_ff);
         rsp_leaf_count    = LC_W'(lc_ff);
         rsp_last_node     = (pos_ff == last_pos);
      end
   end

endmodule

// ===== sv/fnvmt_checker.sv =====
// Port-level checks for the FNV-1a hash tree builder, bound to the top level.
// Depends on fnvmt_pkg and fnv1a_merkle_tree_builder.
module fnvmt_checker
   import fnvmt_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              req_last_leaf,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic [HASH_W-1:0] rsp_node_hash,
   input logic [POS_W-1:0]  rsp_node_position,
   input logic [LC_W-1:0]   rsp_leaf_count,
   input logic              rsp_last_node,
   input logic              rsp_overflow_error
);

   // error item is a lone, empty, final item
   a_err_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_overflow_error |->
         rsp_last_node && rsp_node_position == '0 && rsp_leaf_count == '0 &&
         rsp_node_hash == '0)
      else $error("malformed overflow item");

   // tree words stay inside the tree
   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_overflow_error |->
         rsp_leaf_count != '0 &&
         {1'b0, rsp_node_position} < {rsp_leaf_count, 1'b0})
      else $error("tree word position out of range");

   // one set at a time: no leaf taken while results are pending
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("leaf taken while results pending");

   // a leaf that is not last gives nothing
   a_quiet_leaf: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && !req_last_leaf |=> !rsp_valid)
      else $error("result after a non-final leaf");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=>
         rsp_valid && $stable(rsp_node_hash) && $stable(rsp_node_position))
      else $error("result changed while stalled");

endmodule

bind fnv1a_merkle_tree_builder fnvmt_checker u_checker (.*);

// ===== test/fnv1a_merkle_tree_builder_tb.sv =====
// Self-checking bench for fnv1a_merkle_tree_builder: directed leaf sets, then random ones,
// each tree word compared with a local FNV-1a hash tree model or, for some directed rows,
// a fixed expected word. Needs fnvmt_pkg and the RTL of the block only.
module fnv1a_merkle_tree_builder_tb
   import fnvmt_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int LEAF_CAP   = 32;
   localparam int RAND_ITEMS = 145;
   localparam int LIMIT      = 400000;
   localparam int TAIL       = 64;
   localparam int LONG_HOLD  = 400;
   localparam int HOLD_AT    = 40;

   typedef enum int {READY_FULL, READY_HALF, READY_SPARSE} ready_mode_type;

   typedef struct packed {
      logic [HASH_W-1:0] node_hash;
      logic [POS_W-1:0]  node_position;
      logic [LC_W-1:0]   leaf_count;
      logic              last_node;
      logic              overflow_error;
   } tree_word_type;

   typedef struct {
      logic [HASH_W-1:0] leaf;
      logic              last;
      bit                typed;
      tree_word_type     exp;
   } leaf_item_type;

   typedef struct {
      logic [HASH_W-1:0] leaf;
      int                count;
      bit                last;
      bit                typed;
      logic [HASH_W-1:0] exp_hash;
      int                exp_lc;
      bit                exp_err;
   } dir_row_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   logic [HASH_W-1:0] req_leaf_hash = '0;
   logic              req_last_leaf = 1'b0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   logic [HASH_W-1:0] rsp_node_hash;
   logic [POS_W-1:0]  rsp_node_position;
   logic [LC_W-1:0]   rsp_leaf_count;
   logic              rsp_last_node;
   logic              rsp_overflow_error;

   fnv1a_merkle_tree_builder #(.MAX_LEAVES(LEAF_CAP)) uut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_leaf_hash      (req_leaf_hash),
      .req_last_leaf      (req_last_leaf),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_node_hash      (rsp_node_hash),
      .rsp_node_position  (rsp_node_position),
      .rsp_leaf_count     (rsp_leaf_count),
      .rsp_last_node      (rsp_last_node),
      .rsp_overflow_error (rsp_overflow_error)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // model state
   logic [HASH_W-1:0] leaf_mem [0:LEAF_CAP-1];
   int                leaves_held = 0;
   bit                overflow_flag = 1'b0;
   tree_word_type     fresh_q [$];
   tree_word_type     tree_word_q [$];

   leaf_item_type     leaf_items [$];
   int                drain_idx = 0;
   int                sent_idx = 0;
   int                burst_left = 0;
   int                gap_left = 0;
   bit                all_sent = 1'b0;
   int                errors = 0;
   int                cycle_count = 0;

   function automatic logic [HASH_W-1:0] fnv_word(logic [HASH_W-1:0] h, logic [HASH_W-1:0] w);
      for (int b = 0; b < 4; b++)
         h = (h ^ {24'd0, w[8*b +: 8]}) * FNV_PRIME;
      return h;
   endfunction

   function automatic logic [HASH_W-1:0] fnv_pair(logic [HASH_W-1:0] l, logic [HASH_W-1:0] r);
      return fnv_word(fnv_word(FNV_SEED, l), r);
   endfunction

   // leaves one at a time; on the last leaf the whole tree, or one error word, goes into fresh_q
   task automatic predict_tree_words(input logic [HASH_W-1:0] leaf, input logic last);
      logic [HASH_W-1:0] tree [0:2*LEAF_CAP-2];
      tree_word_type     w;
      int                lc;
      fresh_q.delete();
      if (leaves_held < LEAF_CAP) begin
         leaf_mem[leaves_held] = leaf;
         leaves_held++;
      end else begin
         overflow_flag = 1'b1;
      end
      if (last) begin
         if (overflow_flag) begin
            w = '0;
            w.last_node = 1'b1;
            w.overflow_error = 1'b1;
            fresh_q.push_back(w);
         end else begin
            lc = 1;
            while (lc < leaves_held)
               lc <<= 1;
            for (int i = 0; i < lc; i++)
               tree[lc-1+i] = (i < leaves_held) ? leaf_mem[i] : FNV_SEED;
            for (int p = lc - 2; p >= 0; p--)
               tree[p] = fnv_pair(tree[2*p+1], tree[2*p+2]);
            for (int i = 0; i < 2*lc-1; i++) begin
               w.node_hash      = tree[i];
               w.node_position  = i[POS_W-1:0];
               w.leaf_count     = lc[LC_W-1:0];
               w.last_node      = (i == 2*lc-2);
               w.overflow_error = 1'b0;
               fresh_q.push_back(w);
            end
         end
         leaves_held = 0;
         overflow_flag = 1'b0;
      end
   endtask

   task automatic check_field(input string name, input logic [HASH_W-1:0] exp_v,
                              input logic [HASH_W-1:0] act_v);
      if (act_v !== exp_v) begin
         errors++;
         $display("%0t: %s mismatch, expected %h, got %h", $realtime, name, exp_v, act_v);
      end
   endtask

   // sender, model and checker share one process so the queue is never raced
   always @(posedge clock) begin
      tree_word_type w;
      cycle_count++;
      if (reset) begin
         req_valid     <= 1'b0;
         req_leaf_hash <= '0;
         req_last_leaf <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (tree_word_q.size() == 0) begin
               errors++;
               $display("%0t: unexpected item, expected none, got hash %h pos %0d", $realtime,
                        rsp_node_hash, rsp_node_position);
            end else begin
               w = tree_word_q.pop_front();
               check_field("node_hash", w.node_hash, rsp_node_hash);
               check_field("node_position", w.node_position, rsp_node_position);
               check_field("leaf_count", w.leaf_count, rsp_leaf_count);
               check_field("last_node", w.last_node, rsp_last_node);
               check_field("overflow_error", w.overflow_error, rsp_overflow_error);
            end
         end
         if (req_valid && req_ready) begin
            predict_tree_words(leaf_items[sent_idx].leaf, leaf_items[sent_idx].last);
            if (leaf_items[sent_idx].typed)
               tree_word_q.push_back(leaf_items[sent_idx].exp);
            else
               foreach (fresh_q[i]) tree_word_q.push_back(fresh_q[i]);
            sent_idx++;
         end
         if (!req_valid || req_ready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (sent_idx == drain_idx && tree_word_q.size() != 0) begin
               req_valid <= 1'b0;   // let the directed part drain fully
            end else if (sent_idx < leaf_items.size()) begin
               req_valid     <= 1'b1;
               req_leaf_hash <= leaf_items[sent_idx].leaf;
               req_last_leaf <= leaf_items[sent_idx].last;
               if (burst_left > 0) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(1, 16);
                  gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
               end
            end else begin
               req_valid <= 1'b0;
               all_sent = 1'b1;
            end
         end
      end
   end

   // receiver: random stretches of stall patterns, one long hold-off mid-tree
   ready_mode_type ready_mode = READY_FULL;
   int             stretch_left = 0;
   int             hold_left = 0;
   int             words_seen = 0;
   bit             hold_done = 1'b0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready)
            words_seen++;
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (!hold_done && words_seen >= HOLD_AT) begin
            hold_done = 1'b1;
            hold_left = LONG_HOLD;
            rsp_ready <= 1'b0;
         end else begin
            if (stretch_left == 0) begin
               ready_mode = ready_mode_type'($urandom_range(0, 2));
               stretch_left = $urandom_range(10, 80);
            end
            stretch_left--;
            case (ready_mode)
               READY_FULL:   rsp_ready <= 1'b1;
               READY_HALF:   rsp_ready <= ($urandom_range(0, 1) == 0);
               default:      rsp_ready <= ($urandom_range(0, 3) == 0);
            endcase
         end
      end
   end

   initial begin
      dir_row_type   dir_rows [9];
      leaf_item_type it;
      int            n;
      int            r;
      int            rand_count;
      bit            timed_out;

      // leaf, count, last, typed, expected hash, leaf count, error
      dir_rows = '{
         '{32'h0000_0000,  1, 1'b1, 1'b1, 32'h0000_0000, 1, 1'b0},  // lone leaf is the root
         '{32'hFFFF_FFFF,  1, 1'b1, 1'b1, 32'hFFFF_FFFF, 1, 1'b0},
         '{32'h1234_5678,  2, 1'b1, 1'b0, 32'h0, 0, 1'b0},
         '{32'h0000_0000,  3, 1'b1, 1'b0, 32'h0, 0, 1'b0},          // one pad leaf
         '{32'hA5A5_A5A5, 32, 1'b1, 1'b0, 32'h0, 0, 1'b0},          // full capacity
         '{32'h5A5A_5A5A, 33, 1'b1, 1'b1, 32'h0, 0, 1'b1},          // one leaf too many
         '{32'hC0DE_0001,  1, 1'b1, 1'b1, 32'hC0DE_0001, 1, 1'b0},  // clean set after overflow
         '{32'hFFFF_FFF0,  5, 1'b0, 1'b0, 32'h0, 0, 1'b0},          // set spans two rows
         '{32'h8000_0000,  4, 1'b1, 1'b0, 32'h0, 0, 1'b0}
      };
      foreach (dir_rows[k]) begin
         for (int i = 0; i < dir_rows[k].count; i++) begin
            it.leaf  = dir_rows[k].leaf + i;
            it.last  = dir_rows[k].last && (i == dir_rows[k].count - 1);
            it.typed = dir_rows[k].typed && (i == dir_rows[k].count - 1);
            it.exp                = '0;
            it.exp.node_hash      = dir_rows[k].exp_hash;
            it.exp.leaf_count     = dir_rows[k].exp_lc[LC_W-1:0];
            it.exp.last_node      = 1'b1;
            it.exp.overflow_error = dir_rows[k].exp_err;
            leaf_items.push_back(it);
         end
      end
      drain_idx = leaf_items.size();

      // random sets: mostly small trees, some large, a few overflowing
      rand_count = 0;
      while (rand_count < RAND_ITEMS) begin
         r = $urandom_range(0, 99);
         if (r < 70)
            n = $urandom_range(1, 8);
         else if (r < 92)
            n = $urandom_range(9, LEAF_CAP);
         else
            n = $urandom_range(LEAF_CAP + 1, LEAF_CAP + 4);
         for (int i = 0; i < n; i++) begin
            r = $urandom_range(0, 15);
            it.leaf  = (r == 0) ? 32'h0 : (r == 1) ? 32'hFFFF_FFFF : $urandom();
            it.last  = (i == n - 1);
            it.typed = 1'b0;
            it.exp   = '0;
            leaf_items.push_back(it);
         end
         rand_count += n;
      end

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      while ((!all_sent || tree_word_q.size() != 0) && cycle_count < LIMIT)
         @(negedge clock);
      timed_out = (cycle_count >= LIMIT);
      if (!timed_out)
         repeat (TAIL) @(negedge clock);
      if (tree_word_q.size() != 0) begin
         errors++;
         $display("%0t: %0d tree words still expected, none arrived", $realtime,
                  tree_word_q.size());
      end
      if (errors == 0 && !timed_out) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

// ===== fnv1a_merkle_tree_builder.f =====
sv/fnvmt_pkg.sv
sv/fnvmt_node_ram.sv
sv/fnvmt_hash_unit.sv
sv/fnv1a_merkle_tree_builder.sv
sv/fnvmt_checker.sv
test/fnv1a_merkle_tree_builder_tb.sv
